/* hdl/assert_macros.svh */
// Assertion macros shared by the cursor controller modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TCC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCC_ASSERT(lbl, clk, rstn, prop, msg)
`define TCC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* hdl/tcc_pkg.sv */
// Types, codes and constants of the terminal cursor controller.
`default_nettype none
package tcc_pkg;

  localparam int TAB_WIDTH   = 8;
  localparam int MAX_COLUMNS = 255;
  localparam int MAX_ROWS    = 255;
  localparam int ROW_LIMIT   = 511;

  localparam logic [7:0] COLUMNS_RESET = 8'd40;
  localparam logic [7:0] ROWS_RESET    = 8'd28;

  // Queue depths; both must be powers of two so the pointers wrap naturally.
  localparam int OPQ_DEPTH  = 2;
  localparam int OUTQ_DEPTH = 2;

  // Configuration register indexes.
  localparam logic CFG_SCREEN_COLUMNS = 1'b0;
  localparam logic CFG_SCREEN_ROWS    = 1'b1;

  // Control and CSI final bytes.
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CSI_UP    = 8'h41;
  localparam logic [7:0] CSI_DOWN  = 8'h42;
  localparam logic [7:0] CSI_RIGHT = 8'h43;
  localparam logic [7:0] CSI_LEFT  = 8'h44;
  localparam logic [7:0] CSI_POS   = 8'h48;
  localparam logic [7:0] CSI_ED    = 8'h4A;
  localparam logic [7:0] CSI_EL    = 8'h4B;

  typedef enum logic [1:0] {
    KIND_PRINT   = 2'd0,
    KIND_EXECUTE = 2'd1,
    KIND_CSI     = 2'd2,
    KIND_IGNORE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CMD_WRITE      = 3'd0,
    CMD_CLEAR      = 3'd1,
    CMD_AREA_CLEAR = 3'd2,
    CMD_LINE_CLEAR = 3'd3,
    CMD_PART_CLEAR = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ERASE_TO_END    = 2'd0,
    ERASE_TO_CURSOR = 2'd1,
    ERASE_ALL       = 2'd2
  } erase_sel_e;

  typedef enum logic [3:0] {
    OP_PRINT,
    OP_BACKSPACE,
    OP_NEWLINE,
    OP_RETURN,
    OP_TAB,
    OP_VTAB,
    OP_UP,
    OP_DOWN,
    OP_RIGHT,
    OP_LEFT,
    OP_HOME,
    OP_GOTO,
    OP_ERASE_SCREEN,
    OP_ERASE_LINE
  } op_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
    logic [7:0] param_first;
    logic [7:0] param_second;
    logic [4:0] param_count;
  } in_item_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] glyph;
    logic [7:0] col_start;
    logic [7:0] col_end;
    logic [7:0] row_start;
    logic [7:0] row_end;
  } out_item_t;

  // One classified action: arg_a carries the move count or target row,
  // arg_b the target column.
  typedef struct packed {
    op_e        op;
    logic [7:0] glyph;
    logic [7:0] arg_a;
    logic [7:0] arg_b;
    erase_sel_e sel;
  } op_entry_t;

endpackage
`default_nettype wire

/* hdl/tcc_front.sv */
// Front end: decodes a parser action into a cursor operation or drops it.
`default_nettype none
module tcc_front (
  input  wire logic             in_push,
  input  wire logic             in_full,
  input  tcc_pkg::in_item_t     in_data,
  output logic                  opq_push,
  output tcc_pkg::op_entry_t    opq_data
);
  import tcc_pkg::*;

  logic       keep;
  logic [7:0] sel_raw;
  logic [7:0] move_n;

  assign move_n  = (in_data.param_first == 8'd0) ? 8'd1 : in_data.param_first;
  assign sel_raw = (in_data.param_count != 5'd0) ? in_data.param_first : 8'd0;

  always_comb begin
    keep           = 1'b1;
    opq_data.op    = OP_PRINT;
    opq_data.glyph = in_data.char_code;
    opq_data.arg_a = move_n;
    opq_data.arg_b = 8'd0;
    opq_data.sel   = erase_sel_e'(sel_raw[1:0]);
    case (kind_e'(in_data.kind))
      KIND_PRINT: begin
        opq_data.op = OP_PRINT;
      end
      KIND_EXECUTE: begin
        case (in_data.char_code)
          CH_NUL, CH_BEL, CH_FF: keep = 1'b0;
          CH_BS:  opq_data.op = OP_BACKSPACE;
          CH_LF:  opq_data.op = OP_NEWLINE;
          CH_CR:  opq_data.op = OP_RETURN;
          CH_TAB: opq_data.op = OP_TAB;
          CH_VT:  opq_data.op = OP_VTAB;
          default: opq_data.op = OP_PRINT;
        endcase
      end
      KIND_CSI: begin
        case (in_data.char_code)
          CSI_UP: begin
            opq_data.op = OP_UP;
            keep        = (in_data.param_count != 5'd0);
          end
          CSI_DOWN: begin
            opq_data.op = OP_DOWN;
            keep        = (in_data.param_count != 5'd0);
          end
          CSI_RIGHT: begin
            opq_data.op = OP_RIGHT;
            keep        = (in_data.param_count != 5'd0);
          end
          CSI_LEFT: begin
            opq_data.op = OP_LEFT;
            keep        = (in_data.param_count != 5'd0);
          end
          CSI_POS: begin
            // Row and column targets are one-based, with zero read as one.
            opq_data.arg_a = (in_data.param_first == 8'd0) ? 8'd0 :
                             in_data.param_first - 8'd1;
            opq_data.arg_b = (in_data.param_second == 8'd0) ? 8'd0 :
                             in_data.param_second - 8'd1;
            if (in_data.param_count == 5'd0) begin
              opq_data.op = OP_HOME;
            end else if (in_data.param_count == 5'd2) begin
              opq_data.op = OP_GOTO;
            end else begin
              keep = 1'b0;
            end
          end
          CSI_ED: begin
            opq_data.op = OP_ERASE_SCREEN;
            keep        = (sel_raw <= 8'(ERASE_ALL));
          end
          CSI_EL: begin
            opq_data.op = OP_ERASE_LINE;
            keep        = (sel_raw <= 8'(ERASE_ALL));
          end
          default: keep = 1'b0;
        endcase
      end
      default: keep = 1'b0;
    endcase
  end

  assign opq_push = in_push && !in_full && keep;

endmodule
`default_nettype wire

/* hdl/tcc_opq.sv */
// Small queue of decoded operations between the front and back ends.
`default_nettype none
`include "assert_macros.svh"
module tcc_opq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  tcc_pkg::op_entry_t    push_data,
  output logic                  full,
  output logic                  valid,
  input  wire logic             pop,
  output tcc_pkg::op_entry_t    pop_data
);
  import tcc_pkg::*;

  localparam int AW = (OPQ_DEPTH > 1) ? $clog2(OPQ_DEPTH) : 1;
  localparam int CW = $clog2(OPQ_DEPTH + 1);

  op_entry_t       mem_r [OPQ_DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full     = (cnt_r == CW'(OPQ_DEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `TCC_ASSERT(a_opq_bound, clk, rst_n, (cnt_r <= CW'(OPQ_DEPTH)), "op queue overfilled")
  `TCC_ASSERT(a_opq_no_lost_push, clk, rst_n, (push |-> !full), "push into full op queue")
  `TCC_ASSERT(a_opq_count_track, clk, rst_n, ((do_push && !do_pop) |=> (cnt_r != '0)), "op queue lost a word")

endmodule
`default_nettype wire

/* hdl/tcc_back.sv */
// Back end: cursor state, screen size registers and the result queue.
`default_nettype none
`include "assert_macros.svh"
module tcc_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [7:0]       cfg_data,
  input  wire logic             op_valid,
  input  tcc_pkg::op_entry_t    op_data,
  output logic                  op_pop,
  output logic                  out_empty,
  input  wire logic             out_pop,
  output tcc_pkg::out_item_t    out_data
);
  import tcc_pkg::*;

  localparam int AW = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;
  localparam int CW = $clog2(OUTQ_DEPTH + 1);

  logic [7:0] cols_r, rows_r;
  logic [7:0] cfg_sat;
  logic [7:0] col_r, col_nxt;
  logic [8:0] row_r, row_nxt;

  out_item_t     outq_r [OUTQ_DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_fire, outq_room;

  logic          emit;
  out_item_t     res;

  logic [8:0] row_inc, wrap_row, sum9_col, up_diff;
  logic [7:0] wrap_col, left_diff, col_lim, row_lim;
  logic [9:0] down_sum;
  logic       wrap, up_under;

  // Write data saturated into one to the maximum size.
  always_comb begin
    if (cfg_data == 8'd0) begin
      cfg_sat = 8'd1;
    end else if ((cfg_index == CFG_SCREEN_COLUMNS) && (cfg_data > 8'(MAX_COLUMNS))) begin
      cfg_sat = 8'(MAX_COLUMNS);
    end else if ((cfg_index == CFG_SCREEN_ROWS) && (cfg_data > 8'(MAX_ROWS))) begin
      cfg_sat = 8'(MAX_ROWS);
    end else begin
      cfg_sat = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLUMNS_RESET;
      rows_r <= ROWS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SCREEN_COLUMNS) begin
        cols_r <= cfg_sat;
      end else begin
        rows_r <= cfg_sat;
      end
    end
  end

  // Result queue handshake; a pop frees a slot in the same cycle.
  assign out_fire  = out_pop && !out_empty;
  assign out_empty = (cnt_r == '0);
  assign out_data  = outq_r[rd_ptr_r];
  assign outq_room = (cnt_r != CW'(OUTQ_DEPTH)) || out_fire;
  assign op_pop    = op_valid && outq_room;

  always_comb begin
    row_inc   = (row_r == 9'(ROW_LIMIT)) ? row_r : row_r + 9'd1;
    wrap      = (col_r >= cols_r);
    wrap_col  = wrap ? 8'd0 : col_r;
    wrap_row  = wrap ? row_inc : row_r;
    sum9_col  = {1'b0, col_r} + ((op_data.op == OP_TAB) ? 9'(TAB_WIDTH) :
                                 {1'b0, op_data.arg_a});
    up_under  = (row_r < {1'b0, op_data.arg_a});
    up_diff   = row_r - {1'b0, op_data.arg_a};
    down_sum  = {1'b0, row_r} + {2'b00, op_data.arg_a};
    left_diff = col_r - op_data.arg_a;
    col_lim   = (col_r >= cols_r) ? cols_r : col_r;
    row_lim   = (row_r >= {1'b0, rows_r}) ? rows_r : row_r[7:0];
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    emit    = 1'b0;
    res     = '0;
    case (op_data.op)
      OP_PRINT: begin
        col_nxt = wrap_col;
        row_nxt = wrap_row;
        if (wrap_row < {1'b0, rows_r}) begin
          emit          = 1'b1;
          res.command   = CMD_WRITE;
          res.glyph     = op_data.glyph;
          res.col_start = wrap_col;
          res.row_start = wrap_row[7:0];
          col_nxt       = wrap_col + 8'd1;
        end
      end
      OP_BACKSPACE: begin
        if ((col_r != 8'd0) && ((col_r - 8'd1) < cols_r)) begin
          col_nxt = col_r - 8'd1;
        end
      end
      OP_NEWLINE: begin
        col_nxt = 8'd0;
        row_nxt = row_inc;
      end
      OP_RETURN: col_nxt = 8'd0;
      OP_VTAB:   row_nxt = row_inc;
      OP_TAB: begin
        if (sum9_col >= {1'b0, cols_r}) begin
          if (col_r < cols_r) begin
            col_nxt = cols_r - 8'd1;
          end
        end else begin
          col_nxt = sum9_col[7:0];
        end
      end
      OP_UP: begin
        row_nxt = (up_under || (up_diff >= {1'b0, rows_r})) ? 9'd0 : up_diff;
      end
      OP_DOWN: begin
        row_nxt = (down_sum >= {2'b00, rows_r}) ? {1'b0, rows_r - 8'd1} :
                  down_sum[8:0];
      end
      OP_RIGHT: begin
        col_nxt = (sum9_col >= {1'b0, cols_r}) ? cols_r - 8'd1 : sum9_col[7:0];
      end
      OP_LEFT: begin
        col_nxt = ((col_r < op_data.arg_a) || (left_diff >= cols_r)) ? 8'd0 :
                  left_diff;
      end
      OP_HOME: begin
        col_nxt = 8'd0;
        row_nxt = 9'd0;
      end
      OP_GOTO: begin
        col_nxt = op_data.arg_b;
        row_nxt = {1'b0, op_data.arg_a};
      end
      OP_ERASE_SCREEN: begin
        case (op_data.sel)
          ERASE_TO_END: begin
            if ((col_r == 8'd0) && (row_r == 9'd0)) begin
              emit        = 1'b1;
              res.command = CMD_CLEAR;
            end else if ((col_r < cols_r) && (row_r < {1'b0, rows_r})) begin
              emit          = 1'b1;
              res.command   = CMD_AREA_CLEAR;
              res.col_start = col_r;
              res.col_end   = cols_r;
              res.row_start = row_r[7:0];
              res.row_end   = rows_r;
            end
          end
          ERASE_TO_CURSOR: begin
            if ((col_r != 8'd0) && (row_r != 9'd0)) begin
              emit        = 1'b1;
              res.command = CMD_AREA_CLEAR;
              res.col_end = col_lim;
              res.row_end = row_lim;
            end
          end
          ERASE_ALL: begin
            emit        = 1'b1;
            res.command = CMD_CLEAR;
          end
          default: emit = 1'b0;
        endcase
      end
      OP_ERASE_LINE: begin
        if (row_r < {1'b0, rows_r}) begin
          res.row_start = row_r[7:0];
          case (op_data.sel)
            ERASE_TO_END: begin
              if (col_r < cols_r) begin
                emit = 1'b1;
                if (col_r == 8'd0) begin
                  res.command = CMD_LINE_CLEAR;
                end else begin
                  res.command   = CMD_PART_CLEAR;
                  res.col_start = col_r;
                  res.col_end   = cols_r;
                end
              end
            end
            ERASE_TO_CURSOR: begin
              if (col_r != 8'd0) begin
                emit          = 1'b1;
                res.command   = CMD_PART_CLEAR;
                res.col_end   = col_lim;
              end
            end
            ERASE_ALL: begin
              emit        = 1'b1;
              res.command = CMD_LINE_CLEAR;
            end
            default: emit = 1'b0;
          endcase
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r + CW'(op_pop && emit) - CW'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= 8'd0;
      row_r    <= 9'd0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (op_pop) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (op_pop && emit) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop && emit) begin
      outq_r[wr_ptr_r] <= res;
    end
  end

  `TCC_ASSERT(a_outq_bound, clk, rst_n, (cnt_r <= CW'(OUTQ_DEPTH)), "result queue overfilled")
  `TCC_ASSERT(a_print_advances, clk, rst_n, ((op_pop && emit && (op_data.op == OP_PRINT)) |=> (col_r != 8'd0)), "print did not advance the cursor")
  `TCC_ASSERT(a_visible_row, clk, rst_n, ((op_pop && emit) |-> (row_r <= 9'(ROW_LIMIT))), "result taken from row past the limit")

endmodule
`default_nettype wire

/* hdl/terminal_cursor_controller.sv */
// Top level of the terminal cursor controller.
//
//   Channel  Ports                          Accepted when
//   -------  -----------------------------  -------------------------
//   input    in_push, in_full, in_data      in_push high, in_full low
//   result   out_empty, out_pop, out_data   out_pop high, out_empty low
//   config   cfg_we, cfg_index, cfg_data    cfg_we high
//
// One word is accepted per cycle while in_full is low. A kept word is
// written into the operation queue; the back end then pops it, updates the
// cursor and writes any command it yields into the result queue, whose head
// is shown on out_data. Reset is synchronous and clears the cursor, both
// queues and sets the screen to 40 by 28. The input side reports full only
// when the two-entry operation queue is full, which happens only while the
// two-entry result queue is full.
//
// The front end decodes each parser action into a cursor operation; ignored
// actions, silent controls, unknown CSI finals, moves with no parameters,
// positioning with one or more than two parameters and bad erase selectors
// are dropped right there and never occupy a queue slot. The back end owns the
// cursor and the screen size registers and retires one operation per cycle
// as long as the result queue has a free slot or is being popped.
`default_nettype none
module terminal_cursor_controller (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic            cfg_index,
  input  wire logic [7:0]      cfg_data,
  input  wire logic            in_push,
  output logic                 in_full,
  input  tcc_pkg::in_item_t    in_data,
  output logic                 out_empty,
  input  wire logic            out_pop,
  output tcc_pkg::out_item_t   out_data
);
  import tcc_pkg::*;

  logic      opq_push;
  op_entry_t opq_wdata;
  logic      opq_valid;
  logic      opq_pop;
  op_entry_t opq_rdata;

  // Decoder: classifies the action while it is being accepted.
  tcc_front u_front (
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .opq_push (opq_push),
    .opq_data (opq_wdata)
  );

  // Decouples the decoder from the cursor so each side stalls on its own.
  tcc_opq u_opq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (opq_push),
    .push_data (opq_wdata),
    .full      (in_full),
    .valid     (opq_valid),
    .pop       (opq_pop),
    .pop_data  (opq_rdata)
  );

  // Cursor update and command generation, with its own result queue.
  tcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op_valid  (opq_valid),
    .op_data   (opq_rdata),
    .op_pop    (opq_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
